>>> sv/p2p_pkg.sv
// Shared types and constants for the planar to packed pixel palette block.
// Used by the top level, the palette RAM instance and the port checker.
package p2p_pkg;

    localparam int PaletteEntries = 256;
    localparam int MaxPlanes      = 8;
    localparam int PixelsPerWord  = 16;
    localparam int FullPlanes     = 8;

    localparam int AddrW   = $clog2(PaletteEntries);
    localparam int CntW    = $clog2(PixelsPerWord);
    localparam int IdxW    = 8;
    localparam int ColorW  = 32;
    localparam int PlaneW  = 16;
    localparam int PlanesW = 4;
    localparam int BppW    = 3;
    localparam int CfgIdxW = 1;
    localparam int CfgDatW = 4;

    localparam logic [IdxW-1:0] SubstEntry = 8'd255;

    localparam logic OpWrite   = 1'b0;
    localparam logic OpConvert = 1'b1;

    localparam logic [CfgIdxW-1:0] CfgBytesPerPixel = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgSourcePlanes  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IdxW-1:0]   palette_index;
        logic [ColorW-1:0] palette_value;
        logic [PlaneW-1:0] plane_word_0;
        logic [PlaneW-1:0] plane_word_1;
        logic [PlaneW-1:0] plane_word_2;
        logic [PlaneW-1:0] plane_word_3;
        logic [PlaneW-1:0] plane_word_4;
        logic [PlaneW-1:0] plane_word_5;
        logic [PlaneW-1:0] plane_word_6;
        logic [PlaneW-1:0] plane_word_7;
    } t_in_item;

    typedef struct packed {
        logic [ColorW-1:0] pixel_value;
        logic              last_pixel;
    } t_out_item;

endpackage

>>> sv/p2p_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module p2p_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/planar_to_packed_pixel_palette_top.sv
// Planar to packed pixel converter: plane words in, palette-mapped pixels out.
// Depends on p2p_pkg and p2p_ram.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_data): an item with
// op write stores one palette entry and gives no result. An item with op
// convert carries one 16-bit word per bitplane and yields 16 pixels,
// leftmost first, the last one flagged by last_pixel.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): one pixel
// per transfer. The first pixel passes through the palette RAM read register
// and the output register; then one pixel per cycle unless the output stalls.
// A convert item stalls the input while its pixels are read, one palette RAM
// read per pixel through the single read port; the next item is taken in
// the cycle that issues the sixteenth read.
// Configuration (i_cfg_valid / o_cfg_ready): register 0 is bytes per pixel,
// register 1 the number of source planes; write them only while idle.
// A stall on the output freezes the whole read pipeline; nothing is dropped.
// Reset clears the pipeline and restores 4 bytes per pixel and 4 planes.
// Palette contents are undefined after reset until written.
module planar_to_packed_pixel_palette_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  p2p_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output p2p_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [p2p_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [p2p_pkg::CfgDatW-1:0]    i_cfg_data
);

    logic [p2p_pkg::BppW-1:0]    r_bpp;
    logic [p2p_pkg::PlanesW-1:0] r_planes;

    logic                        r_busy;
    logic [p2p_pkg::CntW-1:0]    r_cnt;
    logic [p2p_pkg::PlaneW-1:0]  r_words [p2p_pkg::FullPlanes];

    logic                        r_rd_vld;
    logic                        r_rd_last;
    logic                        r_rd_zero;

    logic                        r_out_vld;
    p2p_pkg::t_out_item          r_out;

    logic                        pipe_en;
    logic                        issue;
    logic                        issue_last;
    logic                        in_acc;
    logic [p2p_pkg::PlanesW-1:0] planes_eff;
    logic [p2p_pkg::FullPlanes:0]   ones_full;
    logic [p2p_pkg::FullPlanes-1:0] color;
    logic [p2p_pkg::IdxW-1:0]    entry;
    logic                        entry_ok;
    logic                        wr_ok;
    logic                        ram_we;
    logic [p2p_pkg::ColorW-1:0]  rdata;
    logic [p2p_pkg::ColorW-1:0]  pix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= p2p_pkg::BppW'(4);
            r_planes <= p2p_pkg::PlanesW'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                p2p_pkg::CfgBytesPerPixel: r_bpp <= i_cfg_data[p2p_pkg::BppW-1:0];
                p2p_pkg::CfgSourcePlanes:  r_planes <= i_cfg_data[p2p_pkg::PlanesW-1:0];
                default: ;
            endcase
        end
    end

    assign pipe_en    = !(r_out_vld && i_out_stall);
    assign issue      = r_busy && pipe_en;
    assign issue_last = issue && (r_cnt == p2p_pkg::CntW'(p2p_pkg::PixelsPerWord - 1));
    assign o_in_stall = r_busy && !issue_last;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_planes > p2p_pkg::PlanesW'(p2p_pkg::MaxPlanes)) begin
            planes_eff = p2p_pkg::PlanesW'(p2p_pkg::MaxPlanes);
        end else begin
            planes_eff = r_planes;
        end
        ones_full = ((p2p_pkg::FullPlanes+1)'(1) << planes_eff) - (p2p_pkg::FullPlanes+1)'(1);
        for (int n = 0; n < p2p_pkg::FullPlanes; n++) begin
            color[n] = r_words[n][p2p_pkg::PlaneW-1]
                       && (p2p_pkg::PlanesW'(n) < planes_eff);
        end
        if ((planes_eff < p2p_pkg::PlanesW'(p2p_pkg::FullPlanes))
            && (color == ones_full[p2p_pkg::FullPlanes-1:0])) begin
            entry = p2p_pkg::SubstEntry;
        end else begin
            entry = color;
        end
    end

    assign entry_ok = {1'b0, entry} < (p2p_pkg::IdxW+1)'(p2p_pkg::PaletteEntries);
    assign wr_ok    = {1'b0, i_in_data.palette_index}
                      < (p2p_pkg::IdxW+1)'(p2p_pkg::PaletteEntries);
    assign ram_we   = in_acc && (i_in_data.op == p2p_pkg::OpWrite) && wr_ok;

    p2p_ram #(
        .Width(p2p_pkg::ColorW),
        .Depth(p2p_pkg::PaletteEntries)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_in_data.palette_index[p2p_pkg::AddrW-1:0]),
        .i_wdata(i_in_data.palette_value),
        .i_re   (issue),
        .i_raddr(entry[p2p_pkg::AddrW-1:0]),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (in_acc && (i_in_data.op == p2p_pkg::OpConvert)) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + p2p_pkg::CntW'(1);
            if (issue_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.op == p2p_pkg::OpConvert)) begin
            r_words[0] <= i_in_data.plane_word_0;
            r_words[1] <= i_in_data.plane_word_1;
            r_words[2] <= i_in_data.plane_word_2;
            r_words[3] <= i_in_data.plane_word_3;
            r_words[4] <= i_in_data.plane_word_4;
            r_words[5] <= i_in_data.plane_word_5;
            r_words[6] <= i_in_data.plane_word_6;
            r_words[7] <= i_in_data.plane_word_7;
        end else if (issue) begin
            for (int n = 0; n < p2p_pkg::FullPlanes; n++) begin
                r_words[n] <= {r_words[n][p2p_pkg::PlaneW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (pipe_en) begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_last <= issue_last;
            r_rd_zero <= !entry_ok;
        end
    end

    always_comb begin
        if (r_rd_zero) begin
            pix = '0;
        end else if (r_bpp <= p2p_pkg::BppW'(2)) begin
            pix = rdata >> 16;
        end else if (r_bpp == p2p_pkg::BppW'(3)) begin
            pix = rdata >> 8;
        end else begin
            pix = rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (pipe_en) begin
            r_out_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en && r_rd_vld) begin
            r_out.pixel_value <= pix;
            r_out.last_pixel  <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> sv/p2p_checker.sv
// Port-level checker for the planar to packed pixel palette block.
// Depends on p2p_pkg; bound to planar_to_packed_pixel_palette_top.
module p2p_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input p2p_pkg::t_in_item           i_in_data,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input p2p_pkg::t_out_item          o_out_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_convert_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.op == p2p_pkg::OpConvert)
        |=> o_in_stall)
        else $error("input taken during conversion");

    a_last_not_twice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.last_pixel
        |=> !(o_out_valid && o_out_data.last_pixel))
        else $error("last pixel flagged on consecutive pixels");

endmodule

bind planar_to_packed_pixel_palette_top p2p_checker u_p2p_checker (.*);
